// ===== hw/rtl/slcdt_pkg.sv =====
// Shared types, character codes and the 14-segment font for the LCD text terminal.
// Used by slcdt_ctrl, slcdt_datapath and segment_lcd_text_terminal.
package slcdt_pkg;

  localparam int COLUMNS_DEF = 6;
  localparam int COL_W       = 3;
  localparam int CHAR_W      = 8;
  localparam int GLYPH_W     = 7;
  localparam int SEG_W       = 14;
  localparam int FONT_N      = 95;

  localparam logic [CHAR_W-1:0]  CODE_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0]  CODE_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0]  CODE_DEL     = 8'h7f;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE  = 7'h20;
  localparam logic [SEG_W-1:0]   SEG_BLANK    = 14'h0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLANK,
    ST_SHIFT,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic blank;
    logic shift;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic printable;
    logic pending;
    logic full;
    logic blank_end;
    logic shift_end;
    logic out_free;
  } status_t;

  localparam logic [SEG_W-1:0] FONT_ROM [FONT_N] = '{
    14'h0000, 14'h0208, 14'h0120, 14'h154e, 14'h156d, 14'h2ee4, 14'h2a8d, 14'h0200,
    14'h0a00, 14'h2080, 14'h3fc0, 14'h1540, 14'h2000, 14'h0440, 14'h1000, 14'h2200,
    14'h003f, 14'h0006, 14'h045b, 14'h044f, 14'h0466, 14'h046d, 14'h047d, 14'h0007,
    14'h047f, 14'h046f, 14'h1100, 14'h2100, 14'h0a00, 14'h0448, 14'h2080, 14'h1403,
    14'h053b, 14'h0477, 14'h0a79, 14'h0039, 14'h208f, 14'h0479, 14'h0471, 14'h043d,
    14'h0476, 14'h1109, 14'h001e, 14'h0674, 14'h0038, 14'h0137, 14'h08b6, 14'h013f,
    14'h0473, 14'h083f, 14'h0c73, 14'h046d, 14'h1101, 14'h003e, 14'h2230, 14'h103e,
    14'h06d4, 14'h046e, 14'h2209, 14'h0039, 14'h0880, 14'h000f, 14'h0202, 14'h0008,
    14'h0080, 14'h1058, 14'h047c, 14'h0458, 14'h045e, 14'h2058, 14'h0071, 14'h060e,
    14'h0474, 14'h1001, 14'h000d, 14'h0a70, 14'h1108, 14'h1454, 14'h0454, 14'h045c,
    14'h0271, 14'h0487, 14'h0050, 14'h0c08, 14'h0078, 14'h001c, 14'h0818, 14'h101c,
    14'h2a80, 14'h080c, 14'h2048, 14'h0a40, 14'h1100, 14'h2480, 14'h0452
  };

  function automatic logic [SEG_W-1:0] glyph_of(input logic [GLYPH_W-1:0] code);
    logic [GLYPH_W-1:0] idx;
    idx = code - GLYPH_SPACE;
    if (code < GLYPH_SPACE || code == GLYPH_W'(CODE_DEL)) begin
      return SEG_BLANK;
    end
    return FONT_ROM[idx];
  endfunction

endpackage

// ===== hw/rtl/slcdt_ctrl.sv =====
// Sequencer for the LCD text terminal: accepts items and issues column-write steps.
// Depends on slcdt_pkg; drives slcdt_datapath through cmd_t, reads status_t.
module slcdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  slcdt_pkg::status_t sts,
  output slcdt_pkg::cmd_t   cmd
);

  slcdt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slcdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != slcdt_pkg::ST_IDLE);
    case (state_r)
      slcdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.printable) begin
            if (sts.pending) begin
              state_nxt = slcdt_pkg::ST_BLANK;
            end else if (sts.full) begin
              state_nxt = slcdt_pkg::ST_SHIFT;
            end else begin
              state_nxt = slcdt_pkg::ST_PUT;
            end
          end
        end
      end
      slcdt_pkg::ST_BLANK: begin
        if (sts.out_free) begin
          cmd.blank = 1'b1;
          if (sts.blank_end) begin
            state_nxt = slcdt_pkg::ST_PUT;
          end
        end
      end
      slcdt_pkg::ST_SHIFT: begin
        if (sts.out_free) begin
          cmd.shift = 1'b1;
          if (sts.shift_end) begin
            state_nxt = slcdt_pkg::ST_PUT;
          end
        end
      end
      slcdt_pkg::ST_PUT: begin
        if (sts.out_free) begin
          cmd.put   = 1'b1;
          state_nxt = slcdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slcdt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/slcdt_datapath.sv =====
// Datapath for the LCD text terminal: text row, write pointer, newline flag and result register.
// Depends on slcdt_pkg; driven by slcdt_ctrl through cmd_t.
module slcdt_datapath #(
  parameter int COLUMNS = slcdt_pkg::COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [slcdt_pkg::CHAR_W-1:0]      in_char_in,
  input  slcdt_pkg::cmd_t                   cmd,
  output slcdt_pkg::status_t                sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [slcdt_pkg::COL_W-1:0]       out_column,
  output logic [slcdt_pkg::GLYPH_W-1:0]     out_glyph_code,
  output logic [slcdt_pkg::SEG_W-1:0]       out_segments,
  output logic                              out_last
);

  localparam int CW = $clog2(COLUMNS);
  localparam int PW = $clog2(COLUMNS + 1);

  logic [slcdt_pkg::GLYPH_W-1:0] text_row_r [COLUMNS];
  logic [slcdt_pkg::GLYPH_W-1:0] char_r;
  logic [PW-1:0]                 ptr_r;
  logic                          pending_r;
  logic [CW-1:0]                 col_r;
  logic [CW-1:0]                 col_plus;
  logic [CW-1:0]                 put_col;
  logic                          full;
  logic                          out_valid_r;
  logic [slcdt_pkg::COL_W-1:0]   out_column_r;
  logic [slcdt_pkg::GLYPH_W-1:0] out_glyph_code_r;
  logic [slcdt_pkg::SEG_W-1:0]   out_segments_r;
  logic                          out_last_r;
  logic [slcdt_pkg::GLYPH_W-1:0] shift_code;
  logic                          step;

  assign full       = (ptr_r == PW'(COLUMNS));
  assign col_plus   = col_r + 1'b1;
  assign put_col    = full ? CW'(COLUMNS - 1) : ptr_r[CW-1:0];
  assign shift_code = text_row_r[col_plus];
  assign step       = cmd.blank | cmd.shift | cmd.put;

  assign sts.printable = (in_char_in >= slcdt_pkg::CODE_SPACE) &&
                         (in_char_in <  slcdt_pkg::CODE_DEL);
  assign sts.pending   = pending_r;
  assign sts.full      = full;
  assign sts.blank_end = (col_r == CW'(COLUMNS - 1));
  assign sts.shift_end = (col_r == CW'(COLUMNS - 2));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        text_row_r[i] <= slcdt_pkg::GLYPH_SPACE;
      end
      ptr_r       <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && in_char_in == slcdt_pkg::CODE_NEWLINE) begin
        pending_r <= 1'b1;
      end
      if (cmd.blank) begin
        text_row_r[col_r] <= slcdt_pkg::GLYPH_SPACE;
        ptr_r             <= '0;
        pending_r         <= 1'b0;
      end
      if (cmd.shift) begin
        text_row_r[col_r] <= shift_code;
      end
      if (cmd.put) begin
        text_row_r[put_col] <= char_r;
        ptr_r               <= full ? ptr_r : ptr_r + 1'b1;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r <= in_char_in[slcdt_pkg::GLYPH_W-1:0];
      col_r  <= pending_r ? CW'(1) : '0;
    end else if (cmd.blank || cmd.shift) begin
      col_r <= col_plus;
    end
    if (cmd.blank) begin
      out_column_r     <= slcdt_pkg::COL_W'(col_r);
      out_glyph_code_r <= slcdt_pkg::GLYPH_SPACE;
      out_segments_r   <= slcdt_pkg::SEG_BLANK;
      out_last_r       <= 1'b0;
    end else if (cmd.shift) begin
      out_column_r     <= slcdt_pkg::COL_W'(col_r);
      out_glyph_code_r <= shift_code;
      out_segments_r   <= slcdt_pkg::glyph_of(shift_code);
      out_last_r       <= 1'b0;
    end else if (cmd.put) begin
      out_column_r     <= slcdt_pkg::COL_W'(put_col);
      out_glyph_code_r <= char_r;
      out_segments_r   <= slcdt_pkg::glyph_of(char_r);
      out_last_r       <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_column     = out_column_r;
  assign out_glyph_code = out_glyph_code_r;
  assign out_segments   = out_segments_r;
  assign out_last       = out_last_r;

endmodule

// ===== hw/rtl/segment_lcd_text_terminal.sv =====
// One-row character terminal for a COLUMNS-wide 14-segment LCD: takes one character
// item per handshake and returns one item per column write (column, character shown,
// segment pattern, last flag). A control code or a code 0x7f and above is taken and
// gives nothing; a newline only arms a flag served by the next printable code.
// A printable code is accepted and then written as one column write normally; on a
// newline it first blanks the other columns, on a full row it first scrolls the row left.
// The single result register takes one column write per cycle while out_stall does not
// hold it; the next item is taken while the last result still waits on out_stall.
// Depends on slcdt_pkg, slcdt_ctrl and slcdt_datapath.
module segment_lcd_text_terminal #(
  parameter int COLUMNS = slcdt_pkg::COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [slcdt_pkg::CHAR_W-1:0]  in_char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [slcdt_pkg::COL_W-1:0]   out_column,
  output logic [slcdt_pkg::GLYPH_W-1:0] out_glyph_code,
  output logic [slcdt_pkg::SEG_W-1:0]   out_segments,
  output logic                          out_last
);

  slcdt_pkg::cmd_t    cmd;
  slcdt_pkg::status_t sts;

  slcdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slcdt_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_in     (in_char_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column     (out_column),
    .out_glyph_code (out_glyph_code),
    .out_segments   (out_segments),
    .out_last       (out_last)
  );

endmodule

// ===== bench/segment_lcd_text_terminal_tb.sv =====
// Self-checking bench for segment_lcd_text_terminal: directed and random character items,
// predicted column writes compared in order, with sender gaps and receiver stalls.
// Depends on slcdt_pkg and segment_lcd_text_terminal.
`timescale 1ns / 1ps

module segment_lcd_text_terminal_tb;

  localparam int NCOL        = slcdt_pkg::COLUMNS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_CHARS  = 45;

  localparam logic [slcdt_pkg::SEG_W-1:0] FONT [slcdt_pkg::FONT_N] = '{
    14'h0000, 14'h0208, 14'h0120, 14'h154e, 14'h156d, 14'h2ee4, 14'h2a8d, 14'h0200,
    14'h0a00, 14'h2080, 14'h3fc0, 14'h1540, 14'h2000, 14'h0440, 14'h1000, 14'h2200,
    14'h003f, 14'h0006, 14'h045b, 14'h044f, 14'h0466, 14'h046d, 14'h047d, 14'h0007,
    14'h047f, 14'h046f, 14'h1100, 14'h2100, 14'h0a00, 14'h0448, 14'h2080, 14'h1403,
    14'h053b, 14'h0477, 14'h0a79, 14'h0039, 14'h208f, 14'h0479, 14'h0471, 14'h043d,
    14'h0476, 14'h1109, 14'h001e, 14'h0674, 14'h0038, 14'h0137, 14'h08b6, 14'h013f,
    14'h0473, 14'h083f, 14'h0c73, 14'h046d, 14'h1101, 14'h003e, 14'h2230, 14'h103e,
    14'h06d4, 14'h046e, 14'h2209, 14'h0039, 14'h0880, 14'h000f, 14'h0202, 14'h0008,
    14'h0080, 14'h1058, 14'h047c, 14'h0458, 14'h045e, 14'h2058, 14'h0071, 14'h060e,
    14'h0474, 14'h1001, 14'h000d, 14'h0a70, 14'h1108, 14'h1454, 14'h0454, 14'h045c,
    14'h0271, 14'h0487, 14'h0050, 14'h0c08, 14'h0078, 14'h001c, 14'h0818, 14'h101c,
    14'h2a80, 14'h080c, 14'h2048, 14'h0a40, 14'h1100, 14'h2480, 14'h0452
  };

  typedef struct packed {
    logic [slcdt_pkg::COL_W-1:0]   column;
    logic [slcdt_pkg::GLYPH_W-1:0] glyph;
    logic [slcdt_pkg::SEG_W-1:0]   segs;
    logic                          last;
  } col_write_t;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic [slcdt_pkg::CHAR_W-1:0]  in_char_in     = '0;
  logic                          out_stall      = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [slcdt_pkg::COL_W-1:0]   out_column;
  logic [slcdt_pkg::GLYPH_W-1:0] out_glyph_code;
  logic [slcdt_pkg::SEG_W-1:0]   out_segments;
  logic                          out_last;

  logic [slcdt_pkg::CHAR_W-1:0]  chars_pending [$];
  col_write_t                    col_writes_due [$];
  logic [slcdt_pkg::GLYPH_W-1:0] shown_row [NCOL];
  int                            cursor;
  logic                          newline_armed;
  int                            gap_pct;
  int                            stall_pct;
  int                            errors;
  int                            cycles;

  segment_lcd_text_terminal #(.COLUMNS(NCOL)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column     (out_column),
    .out_glyph_code (out_glyph_code),
    .out_segments   (out_segments),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [slcdt_pkg::SEG_W-1:0] glyph_segs(
    input logic [slcdt_pkg::GLYPH_W-1:0] code);
    return FONT[code - slcdt_pkg::GLYPH_SPACE];
  endfunction

  task automatic push_col_write(input int col, input logic [slcdt_pkg::GLYPH_W-1:0] code,
                                input logic [slcdt_pkg::SEG_W-1:0] segs, input logic last);
    col_write_t w;
    w.column = slcdt_pkg::COL_W'(col);
    w.glyph  = code;
    w.segs   = segs;
    w.last   = last;
    col_writes_due.push_back(w);
  endtask

  task automatic predict_char_writes(input logic [slcdt_pkg::CHAR_W-1:0] c);
    int i;
    if (c < slcdt_pkg::CODE_SPACE) begin
      if (c == slcdt_pkg::CODE_NEWLINE) newline_armed = 1'b1;
    end else if (c < slcdt_pkg::CODE_DEL) begin
      if (newline_armed) begin
        for (i = 1; i < NCOL; i++) begin
          shown_row[i] = slcdt_pkg::GLYPH_SPACE;
          push_col_write(i, slcdt_pkg::GLYPH_SPACE, slcdt_pkg::SEG_BLANK, 1'b0);
        end
        cursor        = 0;
        newline_armed = 1'b0;
      end
      if (cursor < NCOL) begin
        shown_row[cursor] = c[slcdt_pkg::GLYPH_W-1:0];
        push_col_write(cursor, c[slcdt_pkg::GLYPH_W-1:0],
                       glyph_segs(c[slcdt_pkg::GLYPH_W-1:0]), 1'b1);
        cursor++;
      end else begin
        for (i = 0; i + 1 < NCOL; i++) begin
          shown_row[i] = shown_row[i+1];
          push_col_write(i, shown_row[i], glyph_segs(shown_row[i]), 1'b0);
        end
        shown_row[NCOL-1] = c[slcdt_pkg::GLYPH_W-1:0];
        push_col_write(NCOL - 1, c[slcdt_pkg::GLYPH_W-1:0],
                       glyph_segs(c[slcdt_pkg::GLYPH_W-1:0]), 1'b1);
      end
    end
  endtask

  function automatic logic [slcdt_pkg::CHAR_W-1:0] random_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return slcdt_pkg::CHAR_W'($urandom_range(32, 126));
    if (r < 82) return slcdt_pkg::CODE_NEWLINE;
    if (r < 90) return slcdt_pkg::CHAR_W'($urandom_range(0, 31));
    return slcdt_pkg::CHAR_W'($urandom_range(127, 255));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_char_in <= '0;
    end else begin
      if (in_valid && !in_stall) predict_char_writes(in_char_in);
      if (!in_valid || !in_stall) begin
        if (chars_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid   <= 1'b1;
          in_char_in <= chars_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    col_write_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (col_writes_due.size() == 0) begin
          $display("%0t: unexpected column write col=%0d glyph=%h segs=%h last=%b",
                   $time, out_column, out_glyph_code, out_segments, out_last);
          errors++;
        end else begin
          w = col_writes_due.pop_front();
          if (out_column !== w.column) begin
            $display("%0t: column expected %0d actual %0d", $time, w.column, out_column);
            errors++;
          end
          if (out_glyph_code !== w.glyph) begin
            $display("%0t: glyph_code expected %h actual %h", $time, w.glyph,
                     out_glyph_code);
            errors++;
          end
          if (out_segments !== w.segs) begin
            $display("%0t: segments expected %h actual %h", $time, w.segs, out_segments);
            errors++;
          end
          if (out_last !== w.last) begin
            $display("%0t: last expected %b actual %b", $time, w.last, out_last);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL segment_lcd_text_terminal");
      $finish;
    end
  end

  initial begin
    int i;
    int ph;
    errors        = 0;
    cycles        = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    cursor        = 0;
    newline_armed = 1'b0;
    for (i = 0; i < NCOL; i++) shown_row[i] = slcdt_pkg::GLYPH_SPACE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, ignored codes, repeated newline, newline kept across a high code,
    // fill to full row, scroll twice, newline at full row
    chars_pending.push_back(8'h20);
    chars_pending.push_back(8'h7e);
    chars_pending.push_back(8'h41);
    chars_pending.push_back(8'h00);
    chars_pending.push_back(8'h1f);
    chars_pending.push_back(slcdt_pkg::CODE_DEL);
    chars_pending.push_back(8'hff);
    chars_pending.push_back(slcdt_pkg::CODE_NEWLINE);
    chars_pending.push_back(slcdt_pkg::CODE_NEWLINE);
    chars_pending.push_back(8'h80);
    chars_pending.push_back(8'h21);
    for (i = 0; i < 7; i++) chars_pending.push_back(slcdt_pkg::CHAR_W'(8'h30 + i));
    chars_pending.push_back(slcdt_pkg::CODE_NEWLINE);
    chars_pending.push_back(8'h7a);
    chars_pending.push_back(8'h5f);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 79;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 79;
        end
        default: begin
          gap_pct   = 10;
          stall_pct = 10;
        end
      endcase
      for (i = 0; i < RAND_CHARS; i++) chars_pending.push_back(random_char());
      while (chars_pending.size() != 0 || in_valid) @(posedge clk);
    end

    gap_pct = 0;
    while (col_writes_due.size() != 0) @(posedge clk);
    stall_pct = 0;
    repeat (NCOL + 8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS segment_lcd_text_terminal");
    end else begin
      $display("FAIL segment_lcd_text_terminal");
    end
    $finish;
  end

endmodule
